### hdl/assert_macros.svh
// Assertion shorthands for the RTL; pfrt_dp.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PFRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PFRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pfrt_pkg.sv
`default_nettype none
package pfrt_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int FIDX_W     = $clog2(MAX_FRAMES);
  localparam int FCNT_W     = FIDX_W + 1;
  localparam int ADDR_W     = 32;
  localparam int PAGE_W     = 31;
  localparam int CNT_W      = 32;

  typedef enum logic [1:0] {
    REG_OFFSET_BITS   = 2'd0,
    REG_FRAMES_IN_USE = 2'd1,
    REG_POLICY_MODE   = 2'd2
  } reg_idx_t;

  localparam logic POLICY_LRU = 1'b1;

  typedef struct packed {
    logic [31:0] logical_addr;
    logic        write_ref;
  } in_t;

  typedef struct packed {
    logic [31:0] phys_addr;
    logic        was_fault;
    logic        did_evict;
    logic        did_swap_out;
    logic [5:0]  frame_used;
    logic [31:0] fault_total;
    logic [31:0] swap_in_total;
    logic [31:0] swap_out_total;
  } out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic mru_rd;
    logic mru_wa;
    logic mru_wb;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic lru;
    logic head_is_frame;
  } sts_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_MRU_RD = 7'b0001000,
    ST_MRU_WA = 7'b0010000,
    ST_MRU_WB = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  function automatic logic [FCNT_W-1:0] clamp_n(input logic [FCNT_W-1:0] v);
    logic [FCNT_W-1:0] r;
    r = v;
    if (v == '0) r = FCNT_W'(1);
    else if (v > FCNT_W'(MAX_FRAMES)) r = FCNT_W'(MAX_FRAMES);
    return r;
  endfunction

  // Power-up order of the recency chain: each frame links to its index neighbors.
  function automatic logic [FIDX_W-1:0] next_dflt(input logic [FIDX_W-1:0] i,
                                                  input logic [FCNT_W-1:0] n);
    logic [FCNT_W-1:0] ip1;
    ip1 = {1'b0, i} + FCNT_W'(1);
    return (ip1 < n) ? ip1[FIDX_W-1:0] : '0;
  endfunction

  function automatic logic [FIDX_W-1:0] prev_dflt(input logic [FIDX_W-1:0] i);
    return (i != '0) ? i - FIDX_W'(1) : '0;
  endfunction

endpackage
`default_nettype wire

### hdl/pfrt_ctrl.sv
`default_nettype none
module pfrt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire pfrt_pkg::sts_t sts_i,
  output pfrt_pkg::cmd_t      cmd_o,
  output logic                busy,
  output logic                done_o
);

  pfrt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfrt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfrt_pkg::ST_IDLE:   if (start) state_nxt = pfrt_pkg::ST_SCAN;
      pfrt_pkg::ST_SCAN:   if (sts_i.scan_done) state_nxt = pfrt_pkg::ST_DECIDE;
      pfrt_pkg::ST_DECIDE: begin
        state_nxt = sts_i.lru ? pfrt_pkg::ST_MRU_RD : pfrt_pkg::ST_DONE;
      end
      pfrt_pkg::ST_MRU_RD: begin
        state_nxt = sts_i.head_is_frame ? pfrt_pkg::ST_DONE : pfrt_pkg::ST_MRU_WA;
      end
      pfrt_pkg::ST_MRU_WA: state_nxt = pfrt_pkg::ST_MRU_WB;
      pfrt_pkg::ST_MRU_WB: state_nxt = pfrt_pkg::ST_DONE;
      pfrt_pkg::ST_DONE:   state_nxt = pfrt_pkg::ST_IDLE;
      default:             state_nxt = pfrt_pkg::ST_IDLE;
    endcase
  end

  assign busy         = (state_r != pfrt_pkg::ST_IDLE);
  assign done_o       = (state_r == pfrt_pkg::ST_DONE);
  assign cmd_o.load   = (state_r == pfrt_pkg::ST_IDLE) && start;
  assign cmd_o.scan   = (state_r == pfrt_pkg::ST_SCAN);
  assign cmd_o.decide = (state_r == pfrt_pkg::ST_DECIDE);
  assign cmd_o.mru_rd = (state_r == pfrt_pkg::ST_MRU_RD) && !sts_i.head_is_frame;
  assign cmd_o.mru_wa = (state_r == pfrt_pkg::ST_MRU_WA);
  assign cmd_o.mru_wb = (state_r == pfrt_pkg::ST_MRU_WB);

endmodule
`default_nettype wire

### hdl/pfrt_dp.sv
`default_nettype none
`include "assert_macros.svh"
module pfrt_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire pfrt_pkg::in_t  in_data,
  input  wire pfrt_pkg::cmd_t cmd_i,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_idx,
  input  wire logic [31:0]    cfg_wdata,
  output pfrt_pkg::sts_t      sts_o,
  output pfrt_pkg::out_t      res_o
);

  localparam int FW = pfrt_pkg::FIDX_W;
  localparam int NW = pfrt_pkg::FCNT_W;
  localparam int MF = pfrt_pkg::MAX_FRAMES;

  // Configuration.
  logic [4:0]    ob_r;
  logic [NW-1:0] fiu_r;
  logic          pol_r;

  // Reference being served.
  logic [31:0] addr_r;
  logic        wr_r;

  // Frame table.
  logic [pfrt_pkg::PAGE_W-1:0] fp_mem [MF];
  logic [pfrt_pkg::PAGE_W-1:0] fp_q_r;
  logic [MF-1:0] valid_r, dirty_r;

  // Recency chain; an entry never written since table init reads as index order.
  logic [FW-1:0] nx_mem [MF];
  logic [FW-1:0] pv_mem [MF];
  logic [MF-1:0] nxv_r, pvv_r;
  logic [FW-1:0] nx_q_r, pv_q_r;
  logic          nx_qv_r, pv_qv_r;
  logic [FW-1:0] head_r, tail_r, fifo_r;

  // Scan.
  logic [FW-1:0] idx_r, chk_idx_r, hitf_r, freef_r;
  logic          chk_en_r, chk_vld_r, hit_r, free_r;

  // Result.
  logic [FW-1:0]                frame_r;
  logic                         fault_o_r, evict_r, swout_r;
  logic [pfrt_pkg::CNT_W-1:0]   fault_r, swin_r, swout_cnt_r;

  logic [4:0]    ob;
  logic [NW-1:0] n;
  logic [31:0]   page, offset;
  logic [FW-1:0] victim, dframe, nx_cur, pv_cur;
  logic          evict, swout;
  logic          nx_we, pv_we;
  logic [FW-1:0] nx_wa, nx_wd, pv_wa, pv_wd;

  assign ob     = (ob_r == 5'd0) ? 5'd1 : ob_r;
  assign n      = pfrt_pkg::clamp_n(fiu_r);
  assign page   = addr_r >> ob;
  assign offset = addr_r & ((32'd1 << ob) - 32'd1);

  assign victim = (pol_r == pfrt_pkg::POLICY_LRU) ? tail_r : fifo_r;
  assign evict  = !hit_r && !free_r;
  assign swout  = evict && dirty_r[victim];
  assign dframe = hit_r ? hitf_r : (free_r ? freef_r : victim);

  assign nx_cur = nx_qv_r ? nx_q_r : pfrt_pkg::next_dflt(frame_r, n);
  assign pv_cur = pv_qv_r ? pv_q_r : pfrt_pkg::prev_dflt(frame_r);

  // Unlink the frame first, then put it at the head.
  always_comb begin
    nx_we = 1'b0;
    nx_wa = frame_r;
    nx_wd = head_r;
    pv_we = 1'b0;
    pv_wa = head_r;
    pv_wd = frame_r;
    if (cmd_i.mru_wa) begin
      nx_we = 1'b1;
      nx_wa = pv_cur;
      nx_wd = nx_cur;
      pv_we = (frame_r != tail_r);
      pv_wa = nx_cur;
      pv_wd = pv_cur;
    end else if (cmd_i.mru_wb) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.scan) fp_q_r <= fp_mem[idx_r];
    if (cmd_i.decide) fp_mem[dframe] <= page[pfrt_pkg::PAGE_W-1:0];
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    if (cmd_i.mru_rd) begin
      nx_q_r <= nx_mem[frame_r];
      pv_q_r <= pv_mem[frame_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      addr_r <= in_data.logical_addr;
      wr_r   <= in_data.write_ref;
    end
    if (cmd_i.scan) begin
      chk_idx_r <= idx_r;
      chk_vld_r <= valid_r[idx_r];
    end
    if (cmd_i.mru_rd) begin
      nx_qv_r <= nxv_r[frame_r];
      pv_qv_r <= pvv_r[frame_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_r        <= 5'd12;
      fiu_r       <= NW'(MF);
      pol_r       <= 1'b0;
      valid_r     <= '0;
      dirty_r     <= '0;
      nxv_r       <= '0;
      pvv_r       <= '0;
      head_r      <= '0;
      tail_r      <= FW'(MF - 1);
      fifo_r      <= '0;
      idx_r       <= '0;
      chk_en_r    <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      hitf_r      <= '0;
      freef_r     <= '0;
      frame_r     <= '0;
      fault_o_r   <= 1'b0;
      evict_r     <= 1'b0;
      swout_r     <= 1'b0;
      fault_r     <= '0;
      swin_r      <= '0;
      swout_cnt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pfrt_pkg::REG_OFFSET_BITS: ob_r <= cfg_wdata[4:0];
        pfrt_pkg::REG_FRAMES_IN_USE: begin
          fiu_r   <= cfg_wdata[NW-1:0];
          valid_r <= '0;
          dirty_r <= '0;
          nxv_r   <= '0;
          pvv_r   <= '0;
          head_r  <= '0;
          tail_r  <= FW'(pfrt_pkg::clamp_n(cfg_wdata[NW-1:0]) - NW'(1));
          fifo_r  <= '0;
        end
        pfrt_pkg::REG_POLICY_MODE: pol_r <= cfg_wdata[0];
        default: ;
      endcase
    end else begin
      if (cmd_i.load) begin
        idx_r    <= '0;
        chk_en_r <= 1'b0;
        hit_r    <= 1'b0;
        free_r   <= 1'b0;
      end
      if (cmd_i.scan) begin
        idx_r    <= idx_r + FW'(1);
        chk_en_r <= 1'b1;
        // The lowest index wins for both the hit and the free frame.
        if (chk_en_r) begin
          if (chk_vld_r && fp_q_r == page[pfrt_pkg::PAGE_W-1:0] && !hit_r) begin
            hit_r  <= 1'b1;
            hitf_r <= chk_idx_r;
          end
          if (!chk_vld_r && !free_r) begin
            free_r  <= 1'b1;
            freef_r <= chk_idx_r;
          end
        end
      end
      if (cmd_i.decide) begin
        frame_r   <= dframe;
        fault_o_r <= !hit_r;
        evict_r   <= evict;
        swout_r   <= swout;
        if (hit_r) begin
          if (wr_r) dirty_r[dframe] <= 1'b1;
        end else begin
          valid_r[dframe] <= 1'b1;
          dirty_r[dframe] <= wr_r;
          if (fault_r != '1) fault_r <= fault_r + 1'b1;
          if (swin_r != '1) swin_r <= swin_r + 1'b1;
          if (swout && swout_cnt_r != '1) swout_cnt_r <= swout_cnt_r + 1'b1;
          if (evict && pol_r != pfrt_pkg::POLICY_LRU) begin
            fifo_r <= ({1'b0, fifo_r} + NW'(1) == n) ? '0 : fifo_r + FW'(1);
          end
        end
      end
      if (nx_we) nxv_r[nx_wa] <= 1'b1;
      if (pv_we) pvv_r[pv_wa] <= 1'b1;
      if (cmd_i.mru_wa && frame_r == tail_r) tail_r <= pv_cur;
      if (cmd_i.mru_wb) head_r <= frame_r;
    end
  end

  assign sts_o.scan_done     = cmd_i.scan && chk_en_r && ({1'b0, chk_idx_r} == n - NW'(1));
  assign sts_o.lru           = (pol_r == pfrt_pkg::POLICY_LRU);
  assign sts_o.head_is_frame = (head_r == frame_r);

  assign res_o.phys_addr      = ({{(32 - FW){1'b0}}, frame_r} << ob) | offset;
  assign res_o.was_fault      = fault_o_r;
  assign res_o.did_evict      = evict_r;
  assign res_o.did_swap_out   = swout_r;
  assign res_o.frame_used     = 6'(frame_r);
  assign res_o.fault_total    = fault_r;
  assign res_o.swap_in_total  = swin_r;
  assign res_o.swap_out_total = swout_cnt_r;

  `PFRT_ASSERT_IMP(a_swout_needs_evict, swout_r, evict_r && fault_o_r, "swap-out without eviction")
  `PFRT_ASSERT_IMP(a_ptr_range, 1'b1, ({1'b0, fifo_r} < n) && ({1'b0, tail_r} < n), "pointer past frame count")
  `PFRT_ASSERT_NXT(a_frame_resident, cmd_i.decide, valid_r[frame_r], "served frame not valid")

endmodule
`default_nettype wire

### hdl/page_frame_replacement_translator.sv
// A request runs from start to out_valid through the frame search and, in LRU mode, a
// recency-chain update unless the frame is already at the head; the next start is taken
// the cycle after out_valid. The search reads one table entry per cycle from the page memory.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (synchronous, rst_n low) frees all frames, rebuilds the recency chain in index
// order and clears the counters; the block is ready right after reset.
`default_nettype none
module page_frame_replacement_translator (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire pfrt_pkg::in_t   in_data,
  output logic                 out_valid,
  output pfrt_pkg::out_t       out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [31:0]     cfg_wdata
);

  pfrt_pkg::cmd_t cmd;
  pfrt_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  pfrt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (out_valid)
  );

  pfrt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd_i     (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sts_o     (sts),
    .res_o     (out_data)
  );

endmodule
`default_nettype wire
